// ===== rtl/nnfs_pkg.sv =====
package nnfs_pkg;

  localparam int SCALE_W    = 12;
  localparam int COORD_W    = 12;
  localparam int DST_W      = 15;
  localparam int COLOR_W    = 32;
  localparam int FRAC_W     = 8;
  localparam int PROD_W     = SCALE_W + COORD_W;
  localparam int UNITS_W    = SCALE_W - FRAC_W + 1;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam int MAX_REPEAT_DEF = 8;
  localparam int COORD_BITS_DEF = 12;

  localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(256);

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_SCALE_X = 1'b0,
    REG_SCALE_Y = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic capture;  // latch the incoming pixel
    logic calc;     // compute base position and repeat counts
    logic emit;     // push next destination write when the slot frees
  } cmd_t;

  typedef struct packed {
    logic slot_free;  // output register can take a beat this cycle
    logic last;       // pending write is the final one of the run
    logic empty;      // run has no writes
  } status_t;

  // ceil(s / 1.0) in Q4.8, before the repeat cap
  function automatic logic [UNITS_W-1:0] ceil_units(input logic [SCALE_W-1:0] s);
    logic [SCALE_W:0] sum;
    sum = {1'b0, s} + (SCALE_W+1)'((1 << FRAC_W) - 1);
    return sum[SCALE_W:FRAC_W];
  endfunction

endpackage

// ===== rtl/nearest_neighbor_forward_scaler_top.sv =====
// Channel  | Handshake           | Payload
// ---------+---------------------+-----------------------------------------------
// in       | in_valid/in_ready   | in_src_x, in_src_y, in_pixel_color
// out      | out_valid/out_ready | out_dst_x, out_dst_y, out_dst_color, out_last_write
// cfg      | APB psel/penable    | paddr, pwdata, prdata (scale_x @0, scale_y @4)
//
// A pixel is accepted in ST_IDLE, the scale multiplies run in ST_CALC, then
// ST_EMIT loads one write beat per cycle into the output register while the
// output slot is free. A run with zero repeats leaves ST_EMIT with no writes.
// The next pixel is accepted while the last write of a run still waits.
// out_ready low holds the write sequencer; rst_n is synchronous, active low.
module nearest_neighbor_forward_scaler_top #(
  parameter int MAX_REPEAT = nnfs_pkg::MAX_REPEAT_DEF,
  parameter int COORD_BITS = nnfs_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [nnfs_pkg::COORD_W-1:0]    in_src_x,
  input  logic [nnfs_pkg::COORD_W-1:0]    in_src_y,
  input  logic [nnfs_pkg::COLOR_W-1:0]    in_pixel_color,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [nnfs_pkg::DST_W-1:0]      out_dst_x,
  output logic [nnfs_pkg::DST_W-1:0]      out_dst_y,
  output logic [nnfs_pkg::COLOR_W-1:0]    out_dst_color,
  output logic                            out_last_write,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nnfs_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [nnfs_pkg::APB_DATA_W-1:0] pwdata,
  output logic [nnfs_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import nnfs_pkg::*;

  logic [SCALE_W-1:0] scale_x_r;
  logic [SCALE_W-1:0] scale_y_r;
  logic               wr_en;
  reg_idx_t           reg_idx;
  cmd_t               cmd;
  status_t            status;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_x_r <= SCALE_RESET;
      scale_y_r <= SCALE_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SCALE_X: scale_x_r <= pwdata[SCALE_W-1:0];
        REG_SCALE_Y: scale_y_r <= pwdata[SCALE_W-1:0];
        default:     scale_x_r <= scale_x_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SCALE_X: prdata = APB_DATA_W'(scale_x_r);
      REG_SCALE_Y: prdata = APB_DATA_W'(scale_y_r);
      default:     prdata = '0;
    endcase
  end

  nnfs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  nnfs_dp #(
    .MAX_REPEAT (MAX_REPEAT),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .scale_x     (scale_x_r),
    .scale_y     (scale_y_r),
    .src_x       (in_src_x),
    .src_y       (in_src_y),
    .pixel_color (in_pixel_color),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .dst_x       (out_dst_x),
    .dst_y       (out_dst_y),
    .dst_color   (out_dst_color),
    .last_write  (out_last_write)
  );

endmodule

// ===== rtl/nnfs_ctrl.sv =====
module nnfs_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  nnfs_pkg::status_t status,
  output nnfs_pkg::cmd_t    cmd
);
  import nnfs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.empty) begin
          state_nxt = ST_IDLE;
        end else if (status.slot_free && status.last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.capture = 1'b0;
    cmd.calc    = 1'b0;
    cmd.emit    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = !status.empty;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/nnfs_dp.sv =====
module nnfs_dp #(
  parameter int MAX_REPEAT = nnfs_pkg::MAX_REPEAT_DEF,
  parameter int COORD_BITS = nnfs_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  nnfs_pkg::cmd_t                cmd,
  output nnfs_pkg::status_t             status,
  input  logic [nnfs_pkg::SCALE_W-1:0]  scale_x,
  input  logic [nnfs_pkg::SCALE_W-1:0]  scale_y,
  input  logic [nnfs_pkg::COORD_W-1:0]  src_x,
  input  logic [nnfs_pkg::COORD_W-1:0]  src_y,
  input  logic [nnfs_pkg::COLOR_W-1:0]  pixel_color,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [nnfs_pkg::DST_W-1:0]    dst_x,
  output logic [nnfs_pkg::DST_W-1:0]    dst_y,
  output logic [nnfs_pkg::COLOR_W-1:0]  dst_color,
  output logic                          last_write
);
  import nnfs_pkg::*;

  localparam int CNT_W = $clog2(MAX_REPEAT + 1);
  localparam int OFF_W = (MAX_REPEAT > 1) ? $clog2(MAX_REPEAT) : 1;
  localparam int EFF_BITS = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam logic [COORD_W-1:0] COORD_MASK = COORD_W'((1 << EFF_BITS) - 1);
  localparam logic [UNITS_W-1:0] CAP = UNITS_W'(MAX_REPEAT);

  logic [COORD_W-1:0] sx_r;
  logic [COORD_W-1:0] sy_r;
  logic [COLOR_W-1:0] color_r;
  logic [DST_W-1:0]   base_col_r;
  logic [DST_W-1:0]   base_row_r;
  logic [CNT_W-1:0]   rx_r;
  logic [CNT_W-1:0]   ry_r;
  logic [OFF_W-1:0]   ox_r;
  logic [OFF_W-1:0]   oy_r;

  logic               out_valid_r;
  logic [DST_W-1:0]   out_x_r;
  logic [DST_W-1:0]   out_y_r;
  logic [COLOR_W-1:0] out_color_r;
  logic               out_last_r;

  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [UNITS_W-1:0] units_x;
  logic [UNITS_W-1:0] units_y;
  logic [CNT_W-1:0]   cnt_x;
  logic [CNT_W-1:0]   cnt_y;
  logic               col_end;
  logic               row_end;
  logic               slot_free;
  logic               load;

  assign prod_x  = PROD_W'(scale_x) * PROD_W'(sx_r);
  assign prod_y  = PROD_W'(scale_y) * PROD_W'(sy_r);
  assign units_x = ceil_units(scale_x);
  assign units_y = ceil_units(scale_y);
  assign cnt_x   = (units_x > CAP) ? CNT_W'(MAX_REPEAT) : CNT_W'(units_x);
  assign cnt_y   = (units_y > CAP) ? CNT_W'(MAX_REPEAT) : CNT_W'(units_y);

  assign col_end   = (CNT_W'(ox_r) == rx_r - CNT_W'(1));
  assign row_end   = (CNT_W'(oy_r) == ry_r - CNT_W'(1));
  assign slot_free = !out_valid_r || out_ready;
  assign load      = cmd.emit && slot_free;

  assign status.slot_free = slot_free;
  assign status.last      = col_end && row_end;
  assign status.empty     = (rx_r == '0) || (ry_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sx_r    <= src_x & COORD_MASK;
      sy_r    <= src_y & COORD_MASK;
      color_r <= pixel_color;
    end
    if (cmd.calc) begin
      base_col_r <= prod_x[DST_W+FRAC_W-1:FRAC_W];
      base_row_r <= prod_y[DST_W+FRAC_W-1:FRAC_W];
      rx_r       <= cnt_x;
      ry_r       <= cnt_y;
    end
  end

  // column offset runs inner, row offset outer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ox_r <= '0;
      oy_r <= '0;
    end else if (cmd.calc) begin
      ox_r <= '0;
      oy_r <= '0;
    end else if (load) begin
      if (col_end) begin
        ox_r <= '0;
        oy_r <= oy_r + OFF_W'(1);
      end else begin
        ox_r <= ox_r + OFF_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_x_r     <= base_col_r + DST_W'(ox_r);
      out_y_r     <= base_row_r + DST_W'(oy_r);
      out_color_r <= color_r;
      out_last_r  <= col_end && row_end;
    end
  end

  assign out_valid  = out_valid_r;
  assign dst_x      = out_x_r;
  assign dst_y      = out_y_r;
  assign dst_color  = out_color_r;
  assign last_write = out_last_r;

endmodule
